>>> rtl/core/ttp_pkg.sv
// Shared types and constants for the time text to tenths parser.
// No dependencies; every other file in rtl/core imports this package.
package ttp_pkg;

  // Payload widths
  localparam int CHAR_W   = 8;
  localparam int TIME_W   = 32;
  localparam int FIELD_W  = 16;
  localparam int FRAC_W   = 10;
  localparam int LEN_W    = 3;
  localparam int PEND_W   = 3;
  localparam int DIGIT_W  = 4;
  localparam int MSEC_W   = 17;
  localparam int TENTHS_W = 4;
  localparam int MPROD_W  = 26;
  localparam int SPROD_W  = 20;
  localparam int LOSUM_W  = 21;

  // Queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Character codes
  localparam logic [CHAR_W-1:0] CH_TAB   = 8'd9;
  localparam logic [CHAR_W-1:0] CH_CR    = 8'd13;
  localparam logic [CHAR_W-1:0] CH_SPACE = 8'd32;
  localparam logic [CHAR_W-1:0] CH_POINT = 8'd46;
  localparam logic [CHAR_W-1:0] CH_ZERO  = 8'd48;
  localparam logic [CHAR_W-1:0] CH_NINE  = 8'd57;
  localparam logic [CHAR_W-1:0] CH_COLON = 8'd58;

  // Limits and scale factors
  localparam logic [FIELD_W-1:0] FIELD_MAX  = 16'hFFFF;
  localparam logic [FRAC_W-1:0]  FRAC_MAX   = 10'd999;
  localparam logic [LEN_W-1:0]   LEN_MAX    = 3'd4;
  localparam logic [PEND_W-1:0]  PEND_MAX   = 3'd7;
  localparam logic [1:0]         COLON_MAX  = 2'd2;
  localparam int                 HOUR_TENTHS = 36000;
  localparam int                 MIN_TENTHS  = 600;
  localparam int                 SEC_TENTHS  = 10;
  localparam int                 DECIMAL     = 10;
  localparam int                 MSEC_ONE    = 100;
  localparam int                 MSEC_TWO    = 10;
  localparam int                 MSEC_STEP   = 100;
  localparam int                 MSEC_HALF   = 50;
  localparam int                 TENTHS_MAX  = 10;

  // Character classes produced by the front end
  typedef enum logic [2:0] {
    CC_BLANK,
    CC_DIGIT,
    CC_COLON,
    CC_POINT,
    CC_OTHER
  } char_class_t;

  // Parse phases
  typedef enum logic [1:0] {
    PH_LEAD,
    PH_INT,
    PH_FRAC
  } phase_t;

  // One classified character as it travels through the queue
  typedef struct packed {
    char_class_t          cls;
    logic [DIGIT_W-1:0]   digit;
    logic                 last;
  } ttp_item_t;

endpackage

>>> rtl/core/ttp_ifs.sv
// Valid/ready channel interfaces for characters in and results out.
// Depends on ttp_pkg for payload widths.
interface ttp_char_if import ttp_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] char_code;
  logic              last_char;

  modport source (output valid, char_code, last_char, input ready);
  modport sink   (input valid, char_code, last_char, output ready);
endinterface

interface ttp_result_if import ttp_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [TIME_W-1:0] day_tenths;
  logic              field_overflow;
  logic              empty_text;

  modport source (output valid, day_tenths, field_overflow, empty_text, input ready);
  modport sink   (input valid, day_tenths, field_overflow, empty_text, output ready);
endinterface

>>> rtl/core/ttp_front.sv
// Front end: accepts characters and classifies them for the parser.
// Depends on ttp_pkg and ttp_char_if.
module ttp_front import ttp_pkg::*; (
  ttp_char_if.sink   chars,
  input  logic       queue_full,
  output logic       push,
  output ttp_item_t  push_item
);

  logic [CHAR_W-1:0] code_off;

  // Accept whenever the queue has room
  assign chars.ready = !queue_full;
  assign push        = chars.valid && !queue_full;

  // Classify the character and extract its digit value
  assign code_off = chars.char_code - CH_ZERO;

  always_comb begin
    push_item.digit = code_off[DIGIT_W-1:0];
    push_item.last  = chars.last_char;
    priority if (chars.char_code == CH_SPACE ||
                 (chars.char_code >= CH_TAB && chars.char_code <= CH_CR)) begin
      push_item.cls = CC_BLANK;
    end else if (chars.char_code >= CH_ZERO && chars.char_code <= CH_NINE) begin
      push_item.cls = CC_DIGIT;
    end else if (chars.char_code == CH_COLON) begin
      push_item.cls = CC_COLON;
    end else if (chars.char_code == CH_POINT) begin
      push_item.cls = CC_POINT;
    end else begin
      push_item.cls = CC_OTHER;
    end
  end

endmodule

>>> rtl/core/ttp_queue.sv
// Short request queue between the front end and the parser back end.
// Depends on ttp_pkg for the item type and depth.
module ttp_queue import ttp_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  input  ttp_item_t push_item,
  output logic      full,
  input  logic      pop,
  output logic      not_empty,
  output ttp_item_t pop_item
);

  ttp_item_t         entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;

  assign full      = count == QCNT_W'(QUEUE_DEPTH);
  assign not_empty = count != '0;
  assign pop_item  = entries[rd_ptr];

  // Store pushed requests
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_item;
    end
  end

  // Advance pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

>>> rtl/core/ttp_back.sv
// Back end: runs the field parser on classified characters and computes
// tenths past midnight in a short stalling pipeline. Depends on ttp_pkg.
module ttp_back import ttp_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        item_valid,
  input  ttp_item_t   item,
  output logic        pop,
  ttp_result_if.source result
);

  // Parser state
  phase_t             phase;
  logic [1:0]         colon_count;
  logic [FIELD_W-1:0] field_first;
  logic [FIELD_W-1:0] field_second;
  logic [FIELD_W-1:0] field_third;
  logic               digit_seen;
  logic               field_ended;
  logic [LEN_W-1:0]   frac_len;
  logic [FRAC_W-1:0]  frac_value;
  logic               frac_ended;
  logic [PEND_W-1:0]  pending;
  logic               overflow_seen;

  // Parser state after the current character
  phase_t             phase_next;
  logic [1:0]         colon_count_next;
  logic [FIELD_W-1:0] field_first_next;
  logic [FIELD_W-1:0] field_second_next;
  logic [FIELD_W-1:0] field_third_next;
  logic               digit_seen_next;
  logic               field_ended_next;
  logic [LEN_W-1:0]   frac_len_next;
  logic [FRAC_W-1:0]  frac_value_next;
  logic               frac_ended_next;
  logic [PEND_W-1:0]  pending_next;
  logic               overflow_seen_next;

  // Step helpers
  logic                 is_blank;
  logic                 is_digit;
  logic                 is_colon;
  logic                 is_point;
  phase_t               eff_phase;
  logic [FIELD_W-1:0]   cur_field;
  logic [SPROD_W-1:0]   field_acc;
  logic [FIELD_W-1:0]   field_sat;
  logic [FRAC_W+3:0]    frac_acc;
  logic [LEN_W:0]       frac_sum;

  // Pipeline
  logic                 advance;
  logic                 s1_valid;
  logic                 s2_valid;
  logic                 s3_valid;
  logic                 out_valid;
  logic [FIELD_W-1:0]   s1_hours;
  logic [FIELD_W-1:0]   s1_minutes;
  logic [FIELD_W-1:0]   s1_seconds;
  logic [LEN_W-1:0]     s1_len;
  logic [FRAC_W-1:0]    s1_frac;
  logic                 s1_has_frac;
  logic                 s1_empty;
  logic                 s1_ovf;
  logic [TIME_W-1:0]    s2_hours;
  logic [MPROD_W-1:0]   s2_minutes;
  logic [SPROD_W-1:0]   s2_seconds;
  logic [MSEC_W-1:0]    s2_msec;
  logic                 s2_empty;
  logic                 s2_ovf;
  logic [MSEC_W-1:0]    msec_calc;
  logic [TENTHS_W-1:0]  tenths_calc;
  logic [TIME_W-1:0]    s3_high;
  logic [LOSUM_W-1:0]   s3_low;
  logic                 s3_empty;
  logic                 s3_ovf;
  logic [TIME_W-1:0]    out_time;
  logic                 out_empty;
  logic                 out_ovf;

  // Move everything forward unless the held result is stalled
  assign advance = !out_valid || result.ready;
  assign pop     = item_valid && advance;

  assign is_blank = item.cls == CC_BLANK;
  assign is_digit = item.cls == CC_DIGIT;
  assign is_colon = item.cls == CC_COLON;
  assign is_point = item.cls == CC_POINT;

  assign eff_phase = (phase == PH_LEAD && !is_blank) ? PH_INT : phase;

  // Decimal accumulation for the active field and the fraction
  assign cur_field = (colon_count == 2'd0) ? field_first :
                     (colon_count == 2'd1) ? field_second : field_third;
  assign field_acc = SPROD_W'(cur_field) * SPROD_W'(DECIMAL) + SPROD_W'(item.digit);
  assign field_sat = (field_acc > SPROD_W'(FIELD_MAX)) ? FIELD_MAX : field_acc[FIELD_W-1:0];
  assign frac_acc  = (FRAC_W+4)'(frac_value) * (FRAC_W+4)'(DECIMAL) +
                     (FRAC_W+4)'(item.digit);
  assign frac_sum  = (LEN_W+1)'(frac_len) + (LEN_W+1)'(pending) + 1'b1;

  // Parse one character
  always_comb begin
    phase_next         = phase;
    colon_count_next   = colon_count;
    field_first_next   = field_first;
    field_second_next  = field_second;
    field_third_next   = field_third;
    digit_seen_next    = digit_seen;
    field_ended_next   = field_ended;
    frac_len_next      = frac_len;
    frac_value_next    = frac_value;
    frac_ended_next    = frac_ended;
    pending_next       = pending;
    overflow_seen_next = overflow_seen;
    unique case (eff_phase)
      PH_INT: begin
        phase_next = PH_INT;
        if (is_point) begin
          phase_next      = PH_FRAC;
          digit_seen_next = 1'b0;
        end else if (is_colon && colon_count < COLON_MAX) begin
          colon_count_next = colon_count + 1'b1;
          digit_seen_next  = 1'b0;
          field_ended_next = 1'b0;
        end else if (!field_ended) begin
          if (is_digit) begin
            unique case (colon_count)
              2'd0:    field_first_next  = field_sat;
              2'd1:    field_second_next = field_sat;
              default: field_third_next  = field_sat;
            endcase
            if (field_acc > SPROD_W'(FIELD_MAX)) begin
              overflow_seen_next = 1'b1;
            end
            digit_seen_next = 1'b1;
          end else if (!(is_blank && !digit_seen)) begin
            field_ended_next = 1'b1;
          end
        end
      end
      PH_FRAC: begin
        // count trailing blanks until a later character makes them internal
        if (is_blank) begin
          if (pending < PEND_MAX) begin
            pending_next = pending + 1'b1;
          end
        end else begin
          frac_len_next = (frac_sum > (LEN_W+1)'(LEN_MAX)) ? LEN_MAX : frac_sum[LEN_W-1:0];
          pending_next  = '0;
        end
        if (!frac_ended) begin
          if (is_digit) begin
            frac_value_next = (frac_acc > (FRAC_W+4)'(FRAC_MAX)) ? FRAC_MAX :
                              frac_acc[FRAC_W-1:0];
            digit_seen_next = 1'b1;
          end else if (!(is_blank && !digit_seen)) begin
            frac_ended_next = 1'b1;
          end
        end
      end
      default: begin
      end
    endcase
  end

  // Update parser state; clear it after the last character
  always_ff @(posedge clk) begin
    if (rst || (pop && item.last)) begin
      phase         <= PH_LEAD;
      colon_count   <= '0;
      field_first   <= '0;
      field_second  <= '0;
      field_third   <= '0;
      digit_seen    <= 1'b0;
      field_ended   <= 1'b0;
      frac_len      <= '0;
      frac_value    <= '0;
      frac_ended    <= 1'b0;
      pending       <= '0;
      overflow_seen <= 1'b0;
    end else if (pop) begin
      phase         <= phase_next;
      colon_count   <= colon_count_next;
      field_first   <= field_first_next;
      field_second  <= field_second_next;
      field_third   <= field_third_next;
      digit_seen    <= digit_seen_next;
      field_ended   <= field_ended_next;
      frac_len      <= frac_len_next;
      frac_value    <= frac_value_next;
      frac_ended    <= frac_ended_next;
      pending       <= pending_next;
      overflow_seen <= overflow_seen_next;
    end
  end

  // Scale fraction digits to milliseconds
  always_comb begin
    msec_calc = '0;
    if (s1_has_frac) begin
      unique case (s1_len)
        3'd1:    msec_calc = MSEC_W'(s1_frac) * MSEC_W'(MSEC_ONE);
        3'd2:    msec_calc = MSEC_W'(s1_frac) * MSEC_W'(MSEC_TWO);
        3'd3:    msec_calc = MSEC_W'(s1_frac);
        default: msec_calc = '0;
      endcase
    end
  end

  // Round milliseconds to tenths by threshold compares
  always_comb begin
    tenths_calc = '0;
    for (int k = 1; k <= TENTHS_MAX; k++) begin
      if (s2_msec >= MSEC_W'(k * MSEC_STEP - MSEC_HALF)) begin
        tenths_calc = tenths_calc + 1'b1;
      end
    end
  end

  // Pipeline valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      s3_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else if (advance) begin
      s1_valid  <= pop && item.last;
      s2_valid  <= s1_valid;
      s3_valid  <= s2_valid;
      out_valid <= s3_valid;
    end
  end

  // Pipeline payload: capture fields, multiply, partial sums, final add
  always_ff @(posedge clk) begin
    if (advance) begin
      unique case (colon_count_next)
        2'd0: begin
          s1_hours   <= '0;
          s1_minutes <= '0;
          s1_seconds <= field_first_next;
        end
        2'd1: begin
          s1_hours   <= '0;
          s1_minutes <= field_first_next;
          s1_seconds <= field_second_next;
        end
        default: begin
          s1_hours   <= field_first_next;
          s1_minutes <= field_second_next;
          s1_seconds <= field_third_next;
        end
      endcase
      s1_len      <= frac_len_next;
      s1_frac     <= frac_value_next;
      s1_has_frac <= phase_next == PH_FRAC;
      s1_empty    <= phase_next == PH_LEAD;
      s1_ovf      <= overflow_seen_next;

      s2_hours   <= TIME_W'(s1_hours) * TIME_W'(HOUR_TENTHS);
      s2_minutes <= MPROD_W'(s1_minutes) * MPROD_W'(MIN_TENTHS);
      s2_seconds <= SPROD_W'(s1_seconds) * SPROD_W'(SEC_TENTHS);
      s2_msec    <= msec_calc;
      s2_empty   <= s1_empty;
      s2_ovf     <= s1_ovf;

      s3_high  <= s2_hours + TIME_W'(s2_minutes);
      s3_low   <= LOSUM_W'(s2_seconds) + LOSUM_W'(tenths_calc);
      s3_empty <= s2_empty;
      s3_ovf   <= s2_ovf;

      out_time  <= s3_high + TIME_W'(s3_low);
      out_empty <= s3_empty;
      out_ovf   <= s3_ovf;
    end
  end

  assign result.valid          = out_valid;
  assign result.day_tenths     = out_time;
  assign result.field_overflow = out_ovf;
  assign result.empty_text     = out_empty;

endmodule

>>> rtl/core/time_text_to_tenths_parser.sv
// Path: the last character of a text passes through the queue, then the capture,
// multiply, partial-sum and final-add stages, before its result is valid.
// Throughput: one character per cycle; a held result freezes parser and pipeline,
// and the two-entry queue then fills and stalls the input.
// Reset: synchronous rst clears the queue, parser state and pipeline valids.
// Depends on ttp_pkg, ttp_ifs, ttp_front, ttp_queue and ttp_back.
module time_text_to_tenths_parser import ttp_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  ttp_char_if.sink     chars,
  ttp_result_if.source result
);

  logic      push;
  ttp_item_t push_item;
  logic      queue_full;
  logic      pop;
  logic      queue_valid;
  ttp_item_t pop_item;

  // Classify incoming characters
  ttp_front u_front (
    .chars      (chars),
    .queue_full (queue_full),
    .push       (push),
    .push_item  (push_item)
  );

  // Buffer classified requests
  ttp_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .full      (queue_full),
    .pop       (pop),
    .not_empty (queue_valid),
    .pop_item  (pop_item)
  );

  // Parse and compute the result
  ttp_back u_back (
    .clk        (clk),
    .rst        (rst),
    .item_valid (queue_valid),
    .item       (pop_item),
    .pop        (pop),
    .result     (result)
  );

`ifndef SYNTHESIS
  a_pop_needs_item: assert property (@(posedge clk) disable iff (rst)
    pop |-> queue_valid) else $error("pop from empty queue");

  a_push_needs_room: assert property (@(posedge clk) disable iff (rst)
    push |-> !queue_full) else $error("push into full queue");

  a_no_pop_on_stall: assert property (@(posedge clk) disable iff (rst)
    (result.valid && !result.ready) |-> !pop) else $error("pop while result stalled");

  a_empty_is_zero: assert property (@(posedge clk) disable iff (rst)
    (result.valid && result.empty_text) |->
      (result.day_tenths == '0 && !result.field_overflow))
    else $error("empty text with nonzero result");
`endif

endmodule

>>> dv/testbench.sv
`timescale 1ns / 1ps
// Self-checking bench for time_text_to_tenths_parser: directed rows, then random time texts.
// Depends on ttp_pkg and the ttp_char_if / ttp_result_if interfaces.
module testbench;
  import ttp_pkg::*;

  localparam int CLK_HALF_NS   = 5;
  localparam int RESET_CYCLES  = 9;
  localparam int TOTAL_CHARS   = 600;
  localparam int HOLD_AT_CHARS = 450;
  localparam int HOLD_CYCLES   = 300;
  localparam int DRAIN_CYCLES  = 20;
  localparam int TIMEOUT_NS    = 2_000_000;

  localparam logic [CHAR_W-1:0] CH_NUL = 8'h00;
  localparam logic [CHAR_W-1:0] CH_TOP = 8'hFF;

  typedef struct packed {
    logic [TIME_W-1:0] tenths;
    logic              ovf;
    logic              empty;
  } text_result_t;

  typedef struct packed {
    logic [CHAR_W-1:0] code;
    logic              last;
    logic              typed;
    text_result_t      res;
  } stim_row_t;

  localparam text_result_t NO_RES    = '0;
  localparam text_result_t EMPTY_RES = '{32'd0, 1'b0, 1'b1};
  localparam text_result_t ZERO_RES  = '{32'd0, 1'b0, 1'b0};

  // Directed characters; the expected result is typed in where it is obvious
  localparam int DIR_ROWS = 30;
  localparam stim_row_t DIR_TABLE [DIR_ROWS] = '{
    // whitespace only texts
    '{CH_SPACE,       1'b1, 1'b1, EMPTY_RES},
    '{CH_TAB,         1'b0, 1'b0, NO_RES},
    '{CH_CR,          1'b1, 1'b1, EMPTY_RES},
    // smallest field
    '{CH_ZERO,        1'b1, 1'b1, ZERO_RES},
    // "65536" saturates the seconds field
    '{CH_ZERO + 8'd6, 1'b0, 1'b0, NO_RES},
    '{CH_ZERO + 8'd5, 1'b0, 1'b0, NO_RES},
    '{CH_ZERO + 8'd5, 1'b0, 1'b0, NO_RES},
    '{CH_ZERO + 8'd3, 1'b0, 1'b0, NO_RES},
    '{CH_ZERO + 8'd6, 1'b1, 1'b1, '{32'd655350, 1'b1, 1'b0}},
    // NUL and the top code are plain non-digits
    '{CH_NUL,         1'b1, 1'b1, ZERO_RES},
    '{CH_TOP,         1'b1, 1'b1, ZERO_RES},
    // "1:::5": the third colon ends the seconds field
    '{CH_ZERO + 8'd1, 1'b0, 1'b0, NO_RES},
    '{CH_COLON,       1'b0, 1'b0, NO_RES},
    '{CH_COLON,       1'b0, 1'b0, NO_RES},
    '{CH_COLON,       1'b0, 1'b0, NO_RES},
    '{CH_ZERO + 8'd5, 1'b1, 1'b1, '{32'd36000, 1'b0, 1'b0}},
    // ".95" rounds up to a full second
    '{CH_POINT,       1'b0, 1'b0, NO_RES},
    '{CH_NINE,        1'b0, 1'b0, NO_RES},
    '{CH_ZERO + 8'd5, 1'b1, 1'b1, '{32'd10, 1'b0, 1'b0}},
    // ".1234": fraction too long
    '{CH_POINT,       1'b0, 1'b0, NO_RES},
    '{CH_ZERO + 8'd1, 1'b0, 1'b0, NO_RES},
    '{CH_ZERO + 8'd2, 1'b0, 1'b0, NO_RES},
    '{CH_ZERO + 8'd3, 1'b0, 1'b0, NO_RES},
    '{CH_ZERO + 8'd4, 1'b1, 1'b1, ZERO_RES},
    // "." alone: empty fraction
    '{CH_POINT,       1'b1, 1'b1, ZERO_RES},
    // "9.:5 ": colon inside the fraction, trailing blank
    '{CH_NINE,        1'b0, 1'b0, NO_RES},
    '{CH_POINT,       1'b0, 1'b0, NO_RES},
    '{CH_COLON,       1'b0, 1'b0, NO_RES},
    '{CH_ZERO + 8'd5, 1'b0, 1'b0, NO_RES},
    '{CH_SPACE,       1'b1, 1'b0, NO_RES}
  };

  logic clk;
  logic rst;

  ttp_char_if   chars_if ();
  ttp_result_if result_if ();

  time_text_to_tenths_parser DUT (
    .clk    (clk),
    .rst    (rst),
    .chars  (chars_if),
    .result (result_if)
  );

  // Parser state mirror
  phase_t             ph;
  logic [1:0]         colons;
  logic [FIELD_W-1:0] fld [3];
  bit                 digit_seen;
  bit                 fld_ended;
  bit                 frac_ended;
  bit                 ovf_seen;
  logic [LEN_W-1:0]   frac_len;
  logic [FRAC_W-1:0]  frac_val;
  logic [PEND_W-1:0]  pend;

  text_result_t      pending_times [$];
  logic [CHAR_W-1:0] text_buf [$];

  int  errors;
  int  chars_sent;
  int  results_seen;
  int  empty_seen;
  int  ovf_count;
  int  send_idle;
  int  recv_idle;
  bit  hold_off;

  always #CLK_HALF_NS clk = ~clk;

  function automatic bit is_blank_code(logic [CHAR_W-1:0] c);
    return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
  endfunction

  function automatic bit is_digit_code(logic [CHAR_W-1:0] c);
    return c >= CH_ZERO && c <= CH_NINE;
  endfunction

  function automatic logic [CHAR_W-1:0] pick_blank();
    logic [CHAR_W-1:0] k;
    k = 8'($urandom_range(0, 5));
    return (k == 8'd0) ? CH_SPACE : CH_TAB + k - 8'd1;
  endfunction

  task automatic flag_error(input string msg);
    $display("ERROR @%0t: %s", $realtime, msg);
    errors++;
  endtask

  task automatic clear_parser();
    ph         = PH_LEAD;
    colons     = '0;
    fld[0]     = '0;
    fld[1]     = '0;
    fld[2]     = '0;
    digit_seen = 1'b0;
    fld_ended  = 1'b0;
    frac_ended = 1'b0;
    ovf_seen   = 1'b0;
    frac_len   = '0;
    frac_val   = '0;
    pend       = '0;
  endtask

  // Advance the parser mirror by one accepted character; queue the time on the last one
  task automatic step_parser(input logic [CHAR_W-1:0] c, input logic l, input logic typed,
                             input text_result_t typed_res);
    int v;
    int n;
    longint unsigned h, m, s, t, msec;
    text_result_t r;
    if (ph == PH_LEAD && !is_blank_code(c)) ph = PH_INT;
    if (ph == PH_INT) begin
      if (c == CH_POINT) begin
        ph = PH_FRAC;
        digit_seen = 1'b0;
      end else if (c == CH_COLON && colons < COLON_MAX) begin
        colons++;
        digit_seen = 1'b0;
        fld_ended = 1'b0;
      end else if (!fld_ended) begin
        if (is_digit_code(c)) begin
          v = int'(fld[colons]) * DECIMAL + int'(c) - int'(CH_ZERO);
          if (v > int'(FIELD_MAX)) begin
            v = int'(FIELD_MAX);
            ovf_seen = 1'b1;
          end
          fld[colons] = v[FIELD_W-1:0];
          digit_seen = 1'b1;
        end else if (!(is_blank_code(c) && !digit_seen)) begin
          fld_ended = 1'b1;
        end
      end
    end else if (ph == PH_FRAC) begin
      // length counts blanks only once something follows them
      if (is_blank_code(c)) begin
        if (pend < PEND_MAX) pend++;
      end else begin
        n = int'(frac_len) + int'(pend) + 1;
        frac_len = (n > int'(LEN_MAX)) ? LEN_MAX : n[LEN_W-1:0];
        pend = '0;
      end
      if (!frac_ended) begin
        if (is_digit_code(c)) begin
          v = int'(frac_val) * DECIMAL + int'(c) - int'(CH_ZERO);
          frac_val = (v > int'(FRAC_MAX)) ? FRAC_MAX : v[FRAC_W-1:0];
          digit_seen = 1'b1;
        end else if (!(is_blank_code(c) && !digit_seen)) begin
          frac_ended = 1'b1;
        end
      end
    end

    if (l) begin
      if (ph == PH_LEAD) begin
        r = EMPTY_RES;
      end else begin
        h = 0;
        m = 0;
        t = 0;
        msec = 0;
        case (colons)
          2'd0: s = fld[0];
          2'd1: begin
            m = fld[0];
            s = fld[1];
          end
          default: begin
            h = fld[0];
            m = fld[1];
            s = fld[2];
          end
        endcase
        if (ph == PH_FRAC) begin
          case (frac_len)
            3'd1: msec = MSEC_ONE * frac_val;
            3'd2: msec = MSEC_TWO * frac_val;
            3'd3: msec = frac_val;
            default: msec = 0;
          endcase
          t = (msec + MSEC_HALF) / MSEC_STEP;
        end
        r.tenths = TIME_W'(h * HOUR_TENTHS + m * MIN_TENTHS + s * SEC_TENTHS + t);
        r.ovf    = ovf_seen;
        r.empty  = 1'b0;
      end
      pending_times.push_back(typed ? typed_res : r);
      clear_parser();
    end
  endtask

  // Build one random text: mostly well-formed times, some broken, some blank-only, some noise
  task automatic build_text();
    int kind;
    int nfields;
    int ndig;
    int pos;
    text_buf.delete();
    kind = $urandom_range(0, 11);
    if (kind == 0) begin
      repeat ($urandom_range(1, 8)) text_buf.push_back(8'($urandom_range(0, 255)));
    end else if (kind == 1) begin
      repeat ($urandom_range(1, 3)) text_buf.push_back(pick_blank());
    end else begin
      repeat ($urandom_range(0, 2)) text_buf.push_back(pick_blank());
      nfields = $urandom_range(1, 3);
      for (int f = 0; f < nfields; f++) begin
        if (f > 0) text_buf.push_back(CH_COLON);
        if ($urandom_range(0, 7) == 0) text_buf.push_back(pick_blank());
        ndig = ($urandom_range(0, 15) == 0) ? $urandom_range(5, 6) : $urandom_range(0, 2);
        repeat (ndig) text_buf.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
      end
      if ($urandom_range(0, 2) != 0) begin
        text_buf.push_back(CH_POINT);
        repeat ($urandom_range(0, 4)) text_buf.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
      end
      // break the sequence with one stray character
      if (kind <= 3) begin
        pos = $urandom_range(0, text_buf.size());
        case ($urandom_range(0, 4))
          0: text_buf.insert(pos, pick_blank());
          1: text_buf.insert(pos, CH_COLON);
          2: text_buf.insert(pos, CH_POINT);
          3: text_buf.insert(pos, CH_ZERO + 8'($urandom_range(0, 9)));
          default: text_buf.insert(pos, 8'($urandom_range(0, 255)));
        endcase
      end
      repeat ($urandom_range(0, 2)) text_buf.push_back(pick_blank());
      if (text_buf.size() == 0) text_buf.push_back(CH_ZERO);
    end
  endtask

  // Offer one character, idling first at random, and wait for the request to be taken
  task automatic send_char(input logic [CHAR_W-1:0] c, input logic l, input logic typed,
                           input text_result_t typed_res);
    while ($urandom_range(0, 99) < send_idle) begin
      chars_if.valid     <= 1'b0;
      chars_if.char_code <= 8'($urandom_range(0, 255));
      chars_if.last_char <= 1'($urandom_range(0, 1));
      @(posedge clk);
    end
    chars_if.valid     <= 1'b1;
    chars_if.char_code <= c;
    chars_if.last_char <= l;
    do @(posedge clk); while (!chars_if.ready);
    step_parser(c, l, typed, typed_res);
    chars_sent++;
  endtask

  // Compare one delivered time with the oldest pending one
  task automatic check_result();
    text_result_t want;
    results_seen++;
    if (result_if.empty_text === 1'b1) empty_seen++;
    if (result_if.field_overflow === 1'b1) ovf_count++;
    if (pending_times.size() == 0) begin
      flag_error($sformatf("result %0d arrived with no text pending", results_seen));
      return;
    end
    want = pending_times.pop_front();
    if (result_if.day_tenths !== want.tenths)
      flag_error($sformatf("result %0d day_tenths %0d, want %0d", results_seen,
                           result_if.day_tenths, want.tenths));
    if (result_if.field_overflow !== want.ovf)
      flag_error($sformatf("result %0d field_overflow %b, want %b", results_seen,
                           result_if.field_overflow, want.ovf));
    if (result_if.empty_text !== want.empty)
      flag_error($sformatf("result %0d empty_text %b, want %b", results_seen,
                           result_if.empty_text, want.empty));
  endtask

  // Result side: check on each taken request, then pick the next ready
  initial begin : result_sink
    result_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && result_if.valid === 1'b1 && result_if.ready === 1'b1) check_result();
      result_if.ready <= !hold_off && ($urandom_range(0, 99) >= recv_idle);
    end
  end

  // Long receiver hold-off so the block fills and stalls its input
  initial begin : sink_hold
    hold_off <= 1'b0;
    wait (chars_sent >= HOLD_AT_CHARS);
    @(posedge clk);
    hold_off <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_off <= 1'b0;
  end

  initial begin : watchdog
    #TIMEOUT_NS;
    $display("simulation failed");
    $finish;
  end

  initial begin : stimulus
    clk = 1'b0;
    errors = 0;
    chars_sent = 0;
    results_seen = 0;
    empty_seen = 0;
    ovf_count = 0;
    send_idle = 19;
    recv_idle = 75;
    clear_parser();
    rst                <= 1'b1;
    chars_if.valid     <= 1'b0;
    chars_if.char_code <= '0;
    chars_if.last_char <= 1'b0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    // Walk the directed table
    for (int row = 0; row < DIR_ROWS; row++)
      send_char(DIR_TABLE[row].code, DIR_TABLE[row].last, DIR_TABLE[row].typed,
                DIR_TABLE[row].res);

    // Random texts: swap idle rates at one third, drop idling at two thirds
    while (chars_sent < TOTAL_CHARS) begin
      if (chars_sent >= 2 * TOTAL_CHARS / 3) begin
        send_idle = 0;
        recv_idle = 0;
      end else if (chars_sent >= TOTAL_CHARS / 3) begin
        send_idle = 75;
        recv_idle = 19;
      end
      build_text();
      foreach (text_buf[i])
        send_char(text_buf[i], i == text_buf.size() - 1, 1'b0, NO_RES);
    end
    chars_if.valid <= 1'b0;

    // Drain outstanding results, then allow for stragglers
    while (pending_times.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d characters under three idle profiles and one long output stall.",
             chars_sent);
    $display("Checked %0d times: %0d blank-only texts, %0d with a saturated field.",
             results_seen, empty_seen, ovf_count);
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
